/* hw/rtl/uctseq_pkg.sv */
// Package for the USB control transfer sequencer.
// Stage, URB, action and status codes plus the context and result structs.
// No dependencies.
package uctseq_pkg;

	typedef enum logic [13:0] {
		STG_IDLE            = 14'b00000000000001,
		STG_SETUP           = 14'b00000000000010,
		STG_SETUP_WAIT      = 14'b00000000000100,
		STG_DATA_IN         = 14'b00000000001000,
		STG_DATA_IN_WAIT    = 14'b00000000010000,
		STG_DATA_OUT        = 14'b00000000100000,
		STG_DATA_OUT_WAIT   = 14'b00000001000000,
		STG_STATUS_IN       = 14'b00000010000000,
		STG_STATUS_IN_WAIT  = 14'b00000100000000,
		STG_STATUS_OUT      = 14'b00001000000000,
		STG_STATUS_OUT_WAIT = 14'b00010000000000,
		STG_ERROR           = 14'b00100000000000,
		STG_STALLED         = 14'b01000000000000,
		STG_COMPLETE        = 14'b10000000000000
	} stage_t;

	localparam logic [2:0] URB_DONE      = 3'd1;
	localparam logic [2:0] URB_NOT_READY = 3'd2;
	localparam logic [2:0] URB_ERROR     = 3'd4;
	localparam logic [2:0] URB_STALL     = 3'd5;

	localparam logic [2:0] ACT_NONE       = 3'd0;
	localparam logic [2:0] ACT_SEND_SETUP = 3'd1;
	localparam logic [2:0] ACT_RECV_DATA  = 3'd2;
	localparam logic [2:0] ACT_SEND_DATA  = 3'd3;
	localparam logic [2:0] ACT_RECV_ZLP   = 3'd4;
	localparam logic [2:0] ACT_SEND_ZLP   = 3'd5;
	localparam logic [2:0] ACT_STOP_CH    = 3'd6;

	localparam logic [1:0] RES_BUSY = 2'd0;
	localparam logic [1:0] RES_OK   = 2'd1;
	localparam logic [1:0] RES_FAIL = 2'd2;

	localparam logic [7:0] MAX_ERR_RESET = 8'd2;

	typedef struct packed {
		logic        wait_phase;
		stage_t      stage;
		logic [7:0]  err_cnt;
		logic        dir;
		logic [15:0] len;
	} ctx_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] action_length;
		logic [1:0]  status;
		logic        retries_exhausted;
	} res_t;

	localparam ctx_t CTX_RESET = '{
		wait_phase: 1'b0,
		stage:      STG_SETUP,
		err_cnt:    8'd0,
		dir:        1'b0,
		len:        16'd0
	};

endpackage

/* hw/rtl/uctseq_step.sv */
// Next-state and result logic for one poll of the control transfer sequencer.
// Depends on uctseq_pkg.
module uctseq_step (
	input  uctseq_pkg::ctx_t  cur,
	input  logic              cmd,
	input  logic              request_direction,
	input  logic [15:0]       data_length,
	input  logic [2:0]        out_pipe_urb,
	input  logic [2:0]        in_pipe_urb,
	input  logic [7:0]        max_err,
	output uctseq_pkg::ctx_t  nxt,
	output uctseq_pkg::res_t  res
);

	logic [8:0] err_inc;

	assign err_inc = {1'b0, cur.err_cnt} + 9'd1;

	always_comb begin
		nxt = cur;
		res = '{action: uctseq_pkg::ACT_NONE, action_length: 16'd0,
			status: uctseq_pkg::RES_BUSY, retries_exhausted: 1'b0};
		if (cmd) begin
			nxt = uctseq_pkg::CTX_RESET;
		end else if (!cur.wait_phase) begin
			nxt.dir        = request_direction;
			nxt.len        = data_length;
			nxt.stage      = uctseq_pkg::STG_SETUP;
			nxt.wait_phase = 1'b1;
		end else begin
			unique case (cur.stage)
				uctseq_pkg::STG_SETUP: begin
					res.action = uctseq_pkg::ACT_SEND_SETUP;
					nxt.stage  = uctseq_pkg::STG_SETUP_WAIT;
				end
				uctseq_pkg::STG_SETUP_WAIT: begin
					if (out_pipe_urb == uctseq_pkg::URB_DONE) begin
						if (cur.len != 16'd0)
							nxt.stage = cur.dir ? uctseq_pkg::STG_DATA_IN
								: uctseq_pkg::STG_DATA_OUT;
						else
							nxt.stage = cur.dir ? uctseq_pkg::STG_STATUS_OUT
								: uctseq_pkg::STG_STATUS_IN;
					end else if (out_pipe_urb == uctseq_pkg::URB_ERROR) begin
						nxt.stage = uctseq_pkg::STG_ERROR;
					end
				end
				uctseq_pkg::STG_DATA_IN: begin
					res.action        = uctseq_pkg::ACT_RECV_DATA;
					res.action_length = cur.len;
					nxt.stage         = uctseq_pkg::STG_DATA_IN_WAIT;
				end
				uctseq_pkg::STG_DATA_IN_WAIT: begin
					if (in_pipe_urb == uctseq_pkg::URB_DONE)
						nxt.stage = uctseq_pkg::STG_STATUS_OUT;
					else if (in_pipe_urb == uctseq_pkg::URB_STALL)
						res.status = uctseq_pkg::RES_FAIL;
					else if (in_pipe_urb == uctseq_pkg::URB_ERROR)
						nxt.stage = uctseq_pkg::STG_ERROR;
				end
				uctseq_pkg::STG_DATA_OUT: begin
					res.action        = uctseq_pkg::ACT_SEND_DATA;
					res.action_length = cur.len;
					nxt.stage         = uctseq_pkg::STG_DATA_OUT_WAIT;
				end
				uctseq_pkg::STG_DATA_OUT_WAIT: begin
					if (out_pipe_urb == uctseq_pkg::URB_DONE) begin
						nxt.stage = uctseq_pkg::STG_STATUS_IN;
					end else if (out_pipe_urb == uctseq_pkg::URB_STALL) begin
						nxt.stage  = uctseq_pkg::STG_STALLED;
						res.status = uctseq_pkg::RES_FAIL;
					end else if (out_pipe_urb == uctseq_pkg::URB_NOT_READY) begin
						nxt.stage = uctseq_pkg::STG_DATA_OUT;
					end else if (out_pipe_urb == uctseq_pkg::URB_ERROR) begin
						nxt.stage  = uctseq_pkg::STG_ERROR;
						res.status = uctseq_pkg::RES_FAIL;
					end
				end
				uctseq_pkg::STG_STATUS_IN: begin
					res.action = uctseq_pkg::ACT_RECV_ZLP;
					nxt.stage  = uctseq_pkg::STG_STATUS_IN_WAIT;
				end
				uctseq_pkg::STG_STATUS_IN_WAIT: begin
					if (in_pipe_urb == uctseq_pkg::URB_DONE)
						res.status = uctseq_pkg::RES_OK;
					else if (in_pipe_urb == uctseq_pkg::URB_STALL)
						res.status = uctseq_pkg::RES_FAIL;
					else if (in_pipe_urb == uctseq_pkg::URB_ERROR)
						nxt.stage = uctseq_pkg::STG_ERROR;
				end
				uctseq_pkg::STG_STATUS_OUT: begin
					res.action = uctseq_pkg::ACT_SEND_ZLP;
					nxt.stage  = uctseq_pkg::STG_STATUS_OUT_WAIT;
				end
				uctseq_pkg::STG_STATUS_OUT_WAIT: begin
					if (out_pipe_urb == uctseq_pkg::URB_DONE)
						res.status = uctseq_pkg::RES_OK;
					else if (out_pipe_urb == uctseq_pkg::URB_NOT_READY)
						nxt.stage = uctseq_pkg::STG_STATUS_OUT;
					else if (out_pipe_urb == uctseq_pkg::URB_ERROR)
						nxt.stage = uctseq_pkg::STG_ERROR;
				end
				uctseq_pkg::STG_ERROR: begin
					if (err_inc <= {1'b0, max_err}) begin
						nxt.err_cnt    = err_inc[7:0];
						res.action     = uctseq_pkg::ACT_STOP_CH;
						nxt.stage      = uctseq_pkg::STG_SETUP;
						nxt.wait_phase = 1'b0;
					end else begin
						res.retries_exhausted = 1'b1;
						nxt.err_cnt           = 8'd0;
						res.status            = uctseq_pkg::RES_FAIL;
					end
				end
				default: begin
				end
			endcase
			if (res.status == uctseq_pkg::RES_OK) begin
				nxt.wait_phase = 1'b0;
				nxt.stage      = uctseq_pkg::STG_IDLE;
			end else if (res.status == uctseq_pkg::RES_FAIL) begin
				nxt.wait_phase = 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/usb_control_transfer_sequencer_core.sv */
// Top level of the USB host control transfer sequencer.
// Input register, uctseq_step logic, sequencer state and result register.
// Depends on uctseq_pkg and uctseq_step.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+------------------
//  in      | cmd request_direction data_length         | in_valid/in_stall
//          | out_pipe_urb in_pipe_urb                  |
//  out     | action action_length status               | out_valid/out_stall
//          | retries_exhausted                         |
//  cfg     | cfg_data (max_error_count)                | cfg_valid/cfg_ready
//
// One poll per cycle while in_stall is low; each poll passes through the input register, then the result register.
// The sequencer state updates as a poll moves from the input to the result register.
// out_stall holds the result register and backs up into in_stall only when both are full.
// arst_n clears the state, the valid flags and sets max_error_count to 2.
module usb_control_transfer_sequencer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic        request_direction,
	input  logic [15:0] data_length,
	input  logic [2:0]  out_pipe_urb,
	input  logic [2:0]  in_pipe_urb,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [15:0] action_length,
	output logic [1:0]  status,
	output logic        retries_exhausted,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	logic               valid_s1;
	logic               cmd_s1;
	logic               dir_s1;
	logic [15:0]        len_s1;
	logic [2:0]         urb_out_s1;
	logic [2:0]         urb_in_s1;
	logic               valid_s2;
	uctseq_pkg::res_t   res_s2;
	uctseq_pkg::ctx_t   ctx_q;
	uctseq_pkg::ctx_t   ctx_nxt;
	uctseq_pkg::res_t   res_nxt;
	logic [7:0]         max_err_q;
	logic               out_hold;
	logic               adv;

	assign out_hold  = valid_s2 & out_stall;
	assign adv       = valid_s1 & ~out_hold;
	assign in_stall  = valid_s1 & out_hold;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_err_q <= uctseq_pkg::MAX_ERR_RESET;
		end else if (cfg_valid) begin
			max_err_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1     <= cmd;
			dir_s1     <= request_direction;
			len_s1     <= data_length;
			urb_out_s1 <= out_pipe_urb;
			urb_in_s1  <= in_pipe_urb;
		end
	end

	uctseq_step u_step (
		.cur               (ctx_q),
		.cmd               (cmd_s1),
		.request_direction (dir_s1),
		.data_length       (len_s1),
		.out_pipe_urb      (urb_out_s1),
		.in_pipe_urb       (urb_in_s1),
		.max_err           (max_err_q),
		.nxt               (ctx_nxt),
		.res               (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= uctseq_pkg::CTX_RESET;
		end else if (adv) begin
			ctx_q <= ctx_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!out_hold) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid         = valid_s2;
	assign action            = res_s2.action;
	assign action_length     = res_s2.action_length;
	assign status            = res_s2.status;
	assign retries_exhausted = res_s2.retries_exhausted;

endmodule

/* sim/usb_control_transfer_sequencer_core_tb.sv */
// Self-checking testbench for usb_control_transfer_sequencer_core: a directed table of polls,
// then random control transfers under several error limits, checked by a built-in predictor.
// Depends on uctseq_pkg and the sequencer RTL.
module usb_control_transfer_sequencer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic CMD_POLL   = 1'b0;
	localparam logic CMD_REINIT = 1'b1;

	localparam logic [2:0] URB_IDLE = 3'd0;
	localparam logic [2:0] URB_NYET = 3'd3;
	localparam logic [2:0] URB_BAD6 = 3'd6;
	localparam logic [2:0] URB_BAD7 = 3'd7;

	localparam int IDLE_LIMIT     = 500;
	localparam int POLLS_PER_PASS = 155;
	localparam int SCRIPT_LEN     = 27;

	typedef struct packed {
		logic        cmd;
		logic        dir;
		logic [15:0] len;
		logic [2:0]  uo;
		logic [2:0]  ui;
	} poll_t;

	typedef struct {
		poll_t            poll;
		bit               typed;
		uctseq_pkg::res_t want;
	} row_t;

	localparam uctseq_pkg::res_t R_QUIET =
		'{uctseq_pkg::ACT_NONE, 16'd0, uctseq_pkg::RES_BUSY, 1'b0};
	localparam uctseq_pkg::res_t R_SETUP =
		'{uctseq_pkg::ACT_SEND_SETUP, 16'd0, uctseq_pkg::RES_BUSY, 1'b0};
	localparam uctseq_pkg::res_t R_RDMAX =
		'{uctseq_pkg::ACT_RECV_DATA, 16'hFFFF, uctseq_pkg::RES_BUSY, 1'b0};
	localparam uctseq_pkg::res_t R_WR1 =
		'{uctseq_pkg::ACT_SEND_DATA, 16'd1, uctseq_pkg::RES_BUSY, 1'b0};
	localparam uctseq_pkg::res_t R_SZLP =
		'{uctseq_pkg::ACT_SEND_ZLP, 16'd0, uctseq_pkg::RES_BUSY, 1'b0};
	localparam uctseq_pkg::res_t R_RZLP =
		'{uctseq_pkg::ACT_RECV_ZLP, 16'd0, uctseq_pkg::RES_BUSY, 1'b0};
	localparam uctseq_pkg::res_t R_STOP =
		'{uctseq_pkg::ACT_STOP_CH, 16'd0, uctseq_pkg::RES_BUSY, 1'b0};
	localparam uctseq_pkg::res_t R_OK =
		'{uctseq_pkg::ACT_NONE, 16'd0, uctseq_pkg::RES_OK, 1'b0};
	localparam uctseq_pkg::res_t R_FAIL =
		'{uctseq_pkg::ACT_NONE, 16'd0, uctseq_pkg::RES_FAIL, 1'b0};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        cmd = 1'b0;
	logic        request_direction = 1'b0;
	logic [15:0] data_length = 16'd0;
	logic [2:0]  out_pipe_urb = 3'd0;
	logic [2:0]  in_pipe_urb = 3'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  action;
	logic [15:0] action_length;
	logic [1:0]  status;
	logic        retries_exhausted;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'd0;

	usb_control_transfer_sequencer_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .request_direction(request_direction), .data_length(data_length),
		.out_pipe_urb(out_pipe_urb), .in_pipe_urb(in_pipe_urb),
		.out_valid(out_valid), .out_stall(out_stall),
		.action(action), .action_length(action_length), .status(status),
		.retries_exhausted(retries_exhausted),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// directed walk through every stage except STG_COMPLETE, which the RTL never enters, error limit at its reset value
	row_t script [SCRIPT_LEN] = '{
		'{'{CMD_REINIT, 1'b1, 16'hFFFF, URB_BAD7, URB_BAD7}, 1'b1, R_QUIET},
		'{'{CMD_POLL, 1'b1, 16'hFFFF, URB_IDLE, URB_IDLE}, 1'b1, R_QUIET},
		'{'{CMD_POLL, 1'b0, 16'd0, URB_IDLE, URB_IDLE}, 1'b1, R_SETUP},
		'{'{CMD_POLL, 1'b0, 16'd0, uctseq_pkg::URB_STALL, uctseq_pkg::URB_DONE},
			1'b0, R_QUIET},
		'{'{CMD_POLL, 1'b0, 16'd0, URB_BAD6, URB_BAD7}, 1'b0, R_QUIET},
		'{'{CMD_POLL, 1'b0, 16'd0, uctseq_pkg::URB_DONE, URB_IDLE}, 1'b0, R_QUIET},
		'{'{CMD_POLL, 1'b0, 16'd0, URB_IDLE, URB_IDLE}, 1'b1, R_RDMAX},
		'{'{CMD_POLL, 1'b0, 16'd0, URB_NYET, uctseq_pkg::URB_NOT_READY}, 1'b0, R_QUIET},
		'{'{CMD_POLL, 1'b0, 16'd0, URB_IDLE, uctseq_pkg::URB_DONE}, 1'b0, R_QUIET},
		'{'{CMD_POLL, 1'b0, 16'd0, URB_IDLE, URB_IDLE}, 1'b1, R_SZLP},
		'{'{CMD_POLL, 1'b0, 16'd0, uctseq_pkg::URB_NOT_READY, URB_IDLE}, 1'b0, R_QUIET},
		'{'{CMD_POLL, 1'b0, 16'd0, URB_IDLE, URB_IDLE}, 1'b1, R_SZLP},
		'{'{CMD_POLL, 1'b0, 16'd0, uctseq_pkg::URB_DONE, URB_IDLE}, 1'b1, R_OK},
		'{'{CMD_POLL, 1'b0, 16'd0, URB_IDLE, URB_IDLE}, 1'b0, R_QUIET},
		'{'{CMD_POLL, 1'b0, 16'd0, URB_IDLE, URB_IDLE}, 1'b1, R_SETUP},
		'{'{CMD_POLL, 1'b0, 16'd0, uctseq_pkg::URB_DONE, URB_IDLE}, 1'b0, R_QUIET},
		'{'{CMD_POLL, 1'b0, 16'd0, URB_IDLE, URB_IDLE}, 1'b1, R_RZLP},
		'{'{CMD_POLL, 1'b0, 16'd0, URB_IDLE, uctseq_pkg::URB_STALL}, 1'b1, R_FAIL},
		'{'{CMD_POLL, 1'b0, 16'd1, URB_IDLE, URB_IDLE}, 1'b0, R_QUIET},
		'{'{CMD_POLL, 1'b0, 16'd0, URB_IDLE, URB_IDLE}, 1'b1, R_SETUP},
		'{'{CMD_POLL, 1'b0, 16'd0, uctseq_pkg::URB_ERROR, URB_IDLE}, 1'b0, R_QUIET},
		'{'{CMD_POLL, 1'b0, 16'd0, URB_IDLE, URB_IDLE}, 1'b1, R_STOP},
		'{'{CMD_POLL, 1'b0, 16'd1, URB_IDLE, URB_IDLE}, 1'b0, R_QUIET},
		'{'{CMD_POLL, 1'b0, 16'd0, URB_IDLE, URB_IDLE}, 1'b1, R_SETUP},
		'{'{CMD_POLL, 1'b0, 16'd0, uctseq_pkg::URB_DONE, URB_IDLE}, 1'b0, R_QUIET},
		'{'{CMD_POLL, 1'b0, 16'd0, URB_IDLE, URB_IDLE}, 1'b1, R_WR1},
		'{'{CMD_POLL, 1'b0, 16'd0, uctseq_pkg::URB_STALL, URB_IDLE}, 1'b1, R_FAIL}
	};

	// predictor state
	logic               pr_wait;
	uctseq_pkg::stage_t pr_stage;
	logic [7:0]         pr_errs;
	logic               pr_dir;
	logic [15:0]        pr_len;
	logic [7:0]         pr_max;

	uctseq_pkg::res_t pending_results [$];
	uctseq_pkg::res_t got, want;
	bit   quiet = 1'b0;
	int   mismatches = 0;
	int   polls_sent = 0;
	int   results_seen = 0;
	int   ok_seen = 0;
	int   fail_seen = 0;
	int   unrec_seen = 0;
	int   idle_cycles = 0;

	function automatic uctseq_pkg::res_t next_poll_result(poll_t p);
		uctseq_pkg::res_t r;
		r = R_QUIET;
		if (p.cmd == CMD_REINIT) begin
			pr_wait = 1'b0;
			pr_stage = uctseq_pkg::STG_SETUP;
			pr_errs = 8'd0;
			pr_dir = 1'b0;
			pr_len = 16'd0;
		end else if (!pr_wait) begin
			pr_dir = p.dir;
			pr_len = p.len;
			pr_stage = uctseq_pkg::STG_SETUP;
			pr_wait = 1'b1;
		end else begin
			case (pr_stage)
				uctseq_pkg::STG_SETUP: begin
					r.action = uctseq_pkg::ACT_SEND_SETUP;
					pr_stage = uctseq_pkg::STG_SETUP_WAIT;
				end
				uctseq_pkg::STG_SETUP_WAIT: begin
					if (p.uo == uctseq_pkg::URB_DONE) begin
						if (pr_len != 16'd0) begin
							if (pr_dir) pr_stage = uctseq_pkg::STG_DATA_IN;
							else pr_stage = uctseq_pkg::STG_DATA_OUT;
						end else begin
							if (pr_dir) pr_stage = uctseq_pkg::STG_STATUS_OUT;
							else pr_stage = uctseq_pkg::STG_STATUS_IN;
						end
					end else if (p.uo == uctseq_pkg::URB_ERROR) begin
						pr_stage = uctseq_pkg::STG_ERROR;
					end
				end
				uctseq_pkg::STG_DATA_IN: begin
					r.action = uctseq_pkg::ACT_RECV_DATA;
					r.action_length = pr_len;
					pr_stage = uctseq_pkg::STG_DATA_IN_WAIT;
				end
				uctseq_pkg::STG_DATA_IN_WAIT: begin
					if (p.ui == uctseq_pkg::URB_DONE) pr_stage = uctseq_pkg::STG_STATUS_OUT;
					else if (p.ui == uctseq_pkg::URB_STALL) r.status = uctseq_pkg::RES_FAIL;
					else if (p.ui == uctseq_pkg::URB_ERROR) pr_stage = uctseq_pkg::STG_ERROR;
				end
				uctseq_pkg::STG_DATA_OUT: begin
					r.action = uctseq_pkg::ACT_SEND_DATA;
					r.action_length = pr_len;
					pr_stage = uctseq_pkg::STG_DATA_OUT_WAIT;
				end
				uctseq_pkg::STG_DATA_OUT_WAIT: begin
					if (p.uo == uctseq_pkg::URB_DONE) begin
						pr_stage = uctseq_pkg::STG_STATUS_IN;
					end else if (p.uo == uctseq_pkg::URB_STALL) begin
						pr_stage = uctseq_pkg::STG_STALLED;
						r.status = uctseq_pkg::RES_FAIL;
					end else if (p.uo == uctseq_pkg::URB_NOT_READY) begin
						pr_stage = uctseq_pkg::STG_DATA_OUT;
					end else if (p.uo == uctseq_pkg::URB_ERROR) begin
						pr_stage = uctseq_pkg::STG_ERROR;
						r.status = uctseq_pkg::RES_FAIL;
					end
				end
				uctseq_pkg::STG_STATUS_IN: begin
					r.action = uctseq_pkg::ACT_RECV_ZLP;
					pr_stage = uctseq_pkg::STG_STATUS_IN_WAIT;
				end
				uctseq_pkg::STG_STATUS_IN_WAIT: begin
					if (p.ui == uctseq_pkg::URB_DONE) begin
						pr_stage = uctseq_pkg::STG_COMPLETE;
						r.status = uctseq_pkg::RES_OK;
					end else if (p.ui == uctseq_pkg::URB_STALL) begin
						r.status = uctseq_pkg::RES_FAIL;
					end else if (p.ui == uctseq_pkg::URB_ERROR) begin
						pr_stage = uctseq_pkg::STG_ERROR;
					end
				end
				uctseq_pkg::STG_STATUS_OUT: begin
					r.action = uctseq_pkg::ACT_SEND_ZLP;
					pr_stage = uctseq_pkg::STG_STATUS_OUT_WAIT;
				end
				uctseq_pkg::STG_STATUS_OUT_WAIT: begin
					if (p.uo == uctseq_pkg::URB_DONE) begin
						pr_stage = uctseq_pkg::STG_COMPLETE;
						r.status = uctseq_pkg::RES_OK;
					end else if (p.uo == uctseq_pkg::URB_NOT_READY) begin
						pr_stage = uctseq_pkg::STG_STATUS_OUT;
					end else if (p.uo == uctseq_pkg::URB_ERROR) begin
						pr_stage = uctseq_pkg::STG_ERROR;
					end
				end
				uctseq_pkg::STG_ERROR: begin
					// 9-bit compare so the count never wraps
					if ({1'b0, pr_errs} + 9'd1 <= {1'b0, pr_max}) begin
						pr_errs = pr_errs + 8'd1;
						r.action = uctseq_pkg::ACT_STOP_CH;
						pr_stage = uctseq_pkg::STG_SETUP;
						pr_wait = 1'b0;
					end else begin
						r.retries_exhausted = 1'b1;
						pr_errs = 8'd0;
						r.status = uctseq_pkg::RES_FAIL;
					end
				end
				default: ;
			endcase
			if (r.status == uctseq_pkg::RES_OK) begin
				pr_wait = 1'b0;
				pr_stage = uctseq_pkg::STG_IDLE;
			end else if (r.status == uctseq_pkg::RES_FAIL) begin
				pr_wait = 1'b0;
			end
		end
		return r;
	endfunction

	task automatic flag_mismatch(string what, int got_val, int want_val);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got_val, want_val);
	endtask

	task automatic put_poll(poll_t p, bit typed, uctseq_pkg::res_t typed_want);
		uctseq_pkg::res_t pred;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= p.cmd;
		request_direction <= p.dir;
		data_length <= p.len;
		out_pipe_urb <= p.uo;
		in_pipe_urb <= p.ui;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pred = next_poll_result(p);
		pending_results.push_back(typed ? typed_want : pred);
		polls_sent++;
	endtask

	task automatic set_error_limit(logic [7:0] limit);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= limit;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		pr_max = limit;
	endtask

	function automatic logic [2:0] pick_urb();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return uctseq_pkg::URB_DONE;
		if (r < 60) return uctseq_pkg::URB_NOT_READY;
		if (r < 68) return uctseq_pkg::URB_ERROR;
		if (r < 74) return uctseq_pkg::URB_STALL;
		return 3'($urandom_range(0, 7));
	endfunction

	task automatic random_polls(int n);
		poll_t p;
		int r;
		for (int i = 0; i < n; i++) begin
			p.cmd = ($urandom_range(0, 49) == 0) ? CMD_REINIT : CMD_POLL;
			p.dir = 1'($urandom_range(0, 1));
			r = $urandom_range(0, 99);
			if (r < 30) p.len = 16'd0;
			else if (r < 40) p.len = 16'hFFFF;
			else if (r < 70) p.len = 16'($urandom_range(1, 64));
			else p.len = 16'($urandom);
			p.uo = pick_urb();
			p.ui = pick_urb();
			put_poll(p, 1'b0, R_QUIET);
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			got = '{action, action_length, status, retries_exhausted};
			results_seen++;
			if (got.status == uctseq_pkg::RES_OK) ok_seen++;
			if (got.status == uctseq_pkg::RES_FAIL) fail_seen++;
			if (got.retries_exhausted) unrec_seen++;
			if (pending_results.size() == 0) begin
				flag_mismatch("result with nothing pending, action", got.action, 0);
			end else begin
				want = pending_results.pop_front();
				if (got.action !== want.action)
					flag_mismatch("action", got.action, want.action);
				if (got.action_length !== want.action_length)
					flag_mismatch("action_length", got.action_length, want.action_length);
				if (got.status !== want.status)
					flag_mismatch("status", got.status, want.status);
				if (got.retries_exhausted !== want.retries_exhausted)
					flag_mismatch("retries_exhausted", got.retries_exhausted,
						want.retries_exhausted);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", idle_cycles);
			$display("FAIL usb_control_transfer_sequencer_core");
			$finish;
		end
	end

	initial begin
		logic [7:0] limits [6];
		limits = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(4, 254)), 8'd3, 8'd2};
		pr_wait = 1'b0;
		pr_stage = uctseq_pkg::STG_SETUP;
		pr_errs = 8'd0;
		pr_dir = 1'b0;
		pr_len = 16'd0;
		pr_max = uctseq_pkg::MAX_ERR_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < SCRIPT_LEN; i++)
			put_poll(script[i].poll, script[i].typed, script[i].want);
		in_valid <= 1'b0;
		for (int k = 0; k < 6; k++) begin
			set_error_limit(limits[k]);
			if (k == 5) quiet = 1'b1;
			random_polls(POLLS_PER_PASS);
		end
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("run: %0d polls, %0d results, error limits 0 to 255 and reset value",
			polls_sent, results_seen);
		$display("transfers: %0d ok, %0d failed, %0d unrecovered errors, %0d mismatches",
			ok_seen, fail_seen, unrec_seen, mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASS usb_control_transfer_sequencer_core");
		else
			$display("FAIL usb_control_transfer_sequencer_core");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/uctseq_pkg.sv
hw/rtl/uctseq_step.sv
hw/rtl/usb_control_transfer_sequencer_core.sv
sim/usb_control_transfer_sequencer_core_tb.sv
